/* rtl/lji_pkg.sv */
// Package for the LCG jump-ahead and index recovery block.
// Types, LCG constants and elaboration-time constant functions; no dependencies.
`default_nettype none

package lji_pkg;

	localparam logic [31:0] LCG_MUL     = 32'd1103515245;
	localparam logic [31:0] LCG_INC     = 32'd12345;
	localparam logic [31:0] INC_INV     = 32'd1440005641;
	localparam logic [31:0] START_RESET = 32'h5555_5555;
	localparam int          LADDER_LEN  = 32;
	localparam int          LOG_BITS    = 30;

	// p = 1 + P_SCALE * seed maps a seed to LCG_MUL^n for its index n from zero
	localparam logic [31:0] P_SCALE = INC_INV * (LCG_MUL - 32'd1);

	typedef enum logic [1:0] {
		CMD_JUMP   = 2'd0,
		CMD_INDEX  = 2'd1,
		CMD_LOCATE = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	// one ladder stage's payload
	typedef struct packed {
		logic                vld;
		logic                intl;
		cmd_t                cmd;
		logic [31:0]         seed;
		logic [31:0]         cnt;
		logic [31:0]         p;
		logic [31:0]         am;
		logic [31:0]         aa;
		logic [LOG_BITS-1:0] e;
	} lji_stage_t;

	typedef struct packed {
		logic        vld;
		logic        intl;
		logic [31:0] seed_out;
		logic [31:0] index_out;
		logic [31:0] idx_raw;
		logic [14:0] random_value;
	} lji_res_t;

	// multiplier of the map applied 2^j times
	function automatic logic [31:0] lcg_mul_pow2(input int j);
		logic [31:0] x;
		x = LCG_MUL;
		for (int i = 0; i < j; i++) begin
			x = x * x;
		end
		return x;
	endfunction

	// increment of the map applied 2^j times
	function automatic logic [31:0] lcg_add_pow2(input int j);
		logic [31:0] cm;
		logic [31:0] ca;
		cm = LCG_MUL;
		ca = LCG_INC;
		for (int i = 0; i < j; i++) begin
			ca = ca * (cm + 32'd1);
			cm = cm * cm;
		end
		return ca;
	endfunction

	// multiplier of the map applied n times
	function automatic logic [31:0] lcg_jump_mul(input logic [31:0] n);
		logic [31:0] am;
		logic [31:0] cm;
		am = 32'd1;
		cm = LCG_MUL;
		for (int i = 0; i < 32; i++) begin
			if (n[i]) begin
				am = am * cm;
			end
			cm = cm * cm;
		end
		return am;
	endfunction

	// increment of the map applied n times
	function automatic logic [31:0] lcg_jump_add(input logic [31:0] n);
		logic [31:0] aa;
		logic [31:0] cm;
		logic [31:0] ca;
		aa = 32'd0;
		cm = LCG_MUL;
		ca = LCG_INC;
		for (int i = 0; i < 32; i++) begin
			if (n[i]) begin
				aa = aa * cm + ca;
			end
			ca = ca * (cm + 32'd1);
			cm = cm * cm;
		end
		return aa;
	endfunction

endpackage

`default_nettype wire

/* rtl/lji_ifs.sv */
// Valid/ready channel interfaces for the LCG jump and index block.
// Depends on nothing; the top level uses all three.
`default_nettype none

interface lji_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [31:0] seed_in;
	logic [31:0] step_count;
	modport source (output valid, cmd, seed_in, step_count, input ready);
	modport sink   (input valid, cmd, seed_in, step_count, output ready);
endinterface

interface lji_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] seed_out;
	logic [31:0] index_out;
	logic [14:0] random_value;
	modport source (output valid, seed_out, index_out, random_value, input ready);
	modport sink   (input valid, seed_out, index_out, random_value, output ready);
endinterface

interface lji_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;
	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

/* rtl/lcg_jump_and_index_recovery_top.sv */
// Top level of the LCG jump-ahead and index recovery block.
// Depends on lji_pkg, lji_ifs, lji_stage and lji_finish.
//
// Works on x -> 1103515245*x + 12345 mod 2^32. A transfer on in_ch carries
// cmd, seed_in and step_count; cmd 0 jumps seed_in ahead by step_count, cmd 1
// gives the seed step_count steps after start_seed, cmd 2 gives the number
// of steps from start_seed to seed_in, cmd 3 returns all zeros. Every input
// transfer gives exactly one out_ch transfer, in order. The datapath is a
// 35-register pipeline: one entry stage (seed to power mapping), 32 ladder
// stages, each holding one 32x32 multiply pair for one bit of the count or
// of the discrete log, and two finishing stages (final map or lift check,
// then the output register). It takes one transfer per cycle unless it
// stalls: the whole pipe holds while the output register is full and not
// taken. After reset and after each start_seed write the block runs
// start_seed itself through the pipe to learn its index; in_ch.ready stays
// low meanwhile. Configuration writes are always taken.
`default_nettype none

module lcg_jump_and_index_recovery_top
	import lji_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	lji_in_if.sink     in_ch,
	lji_out_if.source  out_ch,
	lji_cfg_if.sink    cfg
);

	logic [31:0] start_seed_q;
	logic [31:0] start_idx_q;
	logic        init_pending_q;    // start index needs recomputing
	logic        init_busy_q;       // internal item in flight
	logic        en;                // whole pipe advances
	logic        inject;
	logic        in_xfer;
	logic        capture;
	lji_stage_t  entry_s0;
	lji_stage_t  chain [0:LADDER_LEN];
	lji_res_t    res;

	assign en      = !out_ch.valid || out_ch.ready;
	assign inject  = en && init_pending_q && !init_busy_q;
	assign in_ch.ready = en && !init_pending_q && !init_busy_q;
	assign in_xfer = in_ch.valid && in_ch.ready;
	assign capture = en && res.vld && res.intl;
	assign cfg.ready = 1'b1;

	// configuration and start-index bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_seed_q   <= START_RESET;
			start_idx_q    <= '0;
			init_pending_q <= 1'b1;
			init_busy_q    <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				start_seed_q   <= cfg.data;
				init_pending_q <= 1'b1;
			end else if (inject) begin
				init_pending_q <= 1'b0;
			end
			if (inject) begin
				init_busy_q <= 1'b1;
			end else if (capture) begin
				init_busy_q <= 1'b0;
			end
			if (capture) begin
				start_idx_q <= res.idx_raw;
			end
		end
	end

	// entry stage: cmd 1 starts from start_seed; the power target p is formed here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_s0 <= '0;
		end else if (en) begin
			entry_s0.am <= 32'd1;
			entry_s0.aa <= 32'd0;
			entry_s0.e  <= '0;
			if (inject) begin
				entry_s0.vld  <= 1'b1;
				entry_s0.intl <= 1'b1;
				entry_s0.cmd  <= CMD_LOCATE;
				entry_s0.seed <= start_seed_q;
				entry_s0.cnt  <= 32'd0;
				entry_s0.p    <= 32'd1 + P_SCALE * start_seed_q;
			end else begin
				entry_s0.vld  <= in_xfer;
				entry_s0.intl <= 1'b0;
				entry_s0.cmd  <= cmd_t'(in_ch.cmd);
				entry_s0.seed <= (cmd_t'(in_ch.cmd) == CMD_INDEX) ? start_seed_q : in_ch.seed_in;
				entry_s0.cnt  <= in_ch.step_count;
				entry_s0.p    <= 32'd1 + P_SCALE * in_ch.seed_in;
			end
		end
	end

	assign chain[0] = entry_s0;

	// ladder: stage j holds the 2^j-step map; log compares the low j+3 bits
	for (genvar j = 0; j < LADDER_LEN; j++) begin : g_ladder
		localparam logic [31:0] CM     = lcg_mul_pow2(j);
		localparam logic [31:0] CA     = lcg_add_pow2(j);
		localparam logic [31:0] MASK   = (j + 3 >= 32) ? '1 : ((32'd1 << (j + 3)) - 32'd1);
		localparam logic [31:0] SEL    = 32'd1 << j;
		localparam logic        LOG_ON = (j < LOG_BITS);

		lji_stage u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.cm     (CM),
			.ca     (CA),
			.mask   (MASK),
			.sel    (SEL),
			.log_on (LOG_ON),
			.d      (chain[j]),
			.q      (chain[j+1])
		);
	end

	lji_finish u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.start_idx (start_idx_q),
		.d         (chain[LADDER_LEN]),
		.q         (res)
	);

	assign out_ch.valid        = res.vld && !res.intl;
	assign out_ch.seed_out     = res.seed_out;
	assign out_ch.index_out    = res.index_out;
	assign out_ch.random_value = res.random_value;

	// no user transfer while the start index is stale or being computed
	a_no_in_during_init: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |-> !init_pending_q && !init_busy_q)
		else $error("input taken during start index computation");

	// the internal item never reaches the output
	a_intl_hidden: assert property (@(posedge clk) disable iff (!arst_n)
		(res.vld && res.intl) |-> !out_ch.valid)
		else $error("internal item shown on output");

	// capturing the start index ends the busy phase
	a_capture_clears: assert property (@(posedge clk) disable iff (!arst_n)
		capture |=> !init_busy_q)
		else $error("busy not cleared after start index capture");

	a_rand_bits: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_ch.random_value == out_ch.seed_out[30:16])
		else $error("random_value does not follow seed_out");

endmodule

`default_nettype wire

/* rtl/lji_stage.sv */
// One ladder stage: conditional composition with the 2^j-step affine map.
// Depends on lji_pkg.
`default_nettype none

module lji_stage
	import lji_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic [31:0]         cm,
	input  wire logic [31:0]         ca,
	input  wire logic [31:0]         mask,
	input  wire logic [31:0]         sel,
	input  wire logic                log_on,
	input  wire lji_stage_t          d,
	output lji_stage_t               q
);

	lji_stage_t  data_s1;
	logic        cond;
	logic [31:0] am_x;
	logic [31:0] aa_x;

	always_comb begin
		unique case (d.cmd) inside
			CMD_JUMP, CMD_INDEX: cond = |(d.cnt & sel);
			CMD_LOCATE:          cond = log_on && ((d.am & mask) != (d.p & mask));
			default:             cond = 1'b0;
		endcase
	end

	assign am_x = d.am * cm;
	assign aa_x = d.aa * cm + ca;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_s1 <= '0;
		end else if (en) begin
			data_s1 <= d;
			if (cond) begin
				data_s1.am <= am_x;
				data_s1.aa <= aa_x;
				if (d.cmd == CMD_LOCATE) begin
					data_s1.e <= d.e | sel[LOG_BITS-1:0];
				end
			end
		end
	end

	assign q = data_s1;

endmodule

`default_nettype wire

/* rtl/lji_finish.sv */
// Final two stages: apply the jump map or resolve the four index lifts.
// Depends on lji_pkg.
`default_nettype none

module lji_finish
	import lji_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic [31:0] start_idx,
	input  wire lji_stage_t  d,
	output lji_res_t         q
);

	localparam logic [31:0] LIFT1_MUL = lcg_jump_mul(32'h4000_0000);
	localparam logic [31:0] LIFT1_ADD = lcg_jump_add(32'h4000_0000);
	localparam logic [31:0] LIFT2_MUL = lcg_jump_mul(32'h8000_0000);
	localparam logic [31:0] LIFT2_ADD = lcg_jump_add(32'h8000_0000);

	typedef struct packed {
		logic                vld;
		logic                intl;
		cmd_t                cmd;
		logic [31:0]         seed;
		logic [31:0]         aa;
		logic [LOG_BITS-1:0] e;
		logic [31:0]         prod;
		logic [31:0]         m1;
		logic [31:0]         m2;
	} fin_t;

	fin_t        fin_s1;
	lji_res_t    res_s2;
	logic [1:0]  lift;
	logic [31:0] e_full;
	logic [31:0] so;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_s1 <= '0;
		end else if (en) begin
			fin_s1.vld  <= d.vld;
			fin_s1.intl <= d.intl;
			fin_s1.cmd  <= d.cmd;
			fin_s1.seed <= d.seed;
			fin_s1.aa   <= d.aa;
			fin_s1.e    <= d.e;
			fin_s1.prod <= d.am * d.seed;
			fin_s1.m1   <= d.aa * LIFT1_MUL;
			fin_s1.m2   <= d.aa * LIFT2_MUL;
		end
	end

	// first lift whose seed matches; the last one stands if none did
	always_comb begin
		if (fin_s1.aa == fin_s1.seed) begin
			lift = 2'd0;
		end else if (fin_s1.m1 + LIFT1_ADD == fin_s1.seed) begin
			lift = 2'd1;
		end else if (fin_s1.m2 + LIFT2_ADD == fin_s1.seed) begin
			lift = 2'd2;
		end else begin
			lift = 2'd3;
		end
	end

	assign e_full = {lift, fin_s1.e};

	always_comb begin
		unique case (fin_s1.cmd) inside
			CMD_JUMP, CMD_INDEX: so = fin_s1.prod + fin_s1.aa;
			CMD_LOCATE:          so = fin_s1.seed;
			default:             so = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s2 <= '0;
		end else if (en) begin
			res_s2.vld          <= fin_s1.vld;
			res_s2.intl         <= fin_s1.intl;
			res_s2.seed_out     <= so;
			res_s2.idx_raw      <= e_full;
			res_s2.index_out    <= (fin_s1.cmd == CMD_LOCATE) ? e_full - start_idx : 32'd0;
			res_s2.random_value <= so[30:16];
		end
	end

	assign q = res_s2;

endmodule

`default_nettype wire

/* tb/sv/tb_lcg_jump_and_index_recovery_top.sv */
// Testbench for the LCG jump-ahead and index recovery block.
// Depends on lji_pkg, lji_ifs and the block's RTL; needs no files at run time.
`timescale 1ns / 1ps
`default_nettype none

module tb_lcg_jump_and_index_recovery_top;
	import lji_pkg::*;

	localparam int LATENCY     = 36;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [31:0] seed_out;
		logic [31:0] index_out;
		logic [14:0] random_value;
	} lcg_res_t;

	typedef struct {
		cmd_t        cmd;
		logic [31:0] seed;
		logic [31:0] cnt;
		logic        known;
		lcg_res_t    res;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	lji_in_if  in_ch ();
	lji_out_if out_ch ();
	lji_cfg_if cfg ();

	lcg_jump_and_index_recovery_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source),
		.cfg    (cfg.sink)
	);

	// model state: the configured start seed
	logic [31:0] origin_seed;
	lcg_res_t    expected_q[$];
	int          errors = 0;
	int          cycles = 0;
	int          n_sent = 0;
	int          n_got = 0;
	int          n_cmd[4] = '{0, 0, 0, 0};
	int          n_cfg = 0;

	// idling control: percent of cycles the sender idles and receiver stalls
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	bit          hold_off = 1'b0;

	initial begin
		forever #6 clk = ~clk;
	end

	// map x -> m*x + c composed n times, via square-and-multiply on the affine map
	function automatic void lcg_power(input logic [31:0] n, output logic [31:0] m,
			output logic [31:0] c);
		logic [31:0] cm;
		logic [31:0] ca;
		m = 32'd1;
		c = 32'd0;
		cm = LCG_MUL;
		ca = LCG_INC;
		for (int i = 0; i < 32; i++) begin
			if (n[i]) begin
				c = c * cm + ca;
				m = m * cm;
			end
			ca = ca * (cm + 32'd1);
			cm = cm * cm;
		end
	endfunction

	function automatic logic [31:0] lcg_advance(input logic [31:0] s, input logic [31:0] n);
		logic [31:0] m;
		logic [31:0] c;
		lcg_power(n, m, c);
		return m * s + c;
	endfunction

	// index of a seed counted from seed zero: bitwise log of a^n, then lift by 2^30
	function automatic logic [31:0] lcg_index_of(input logic [31:0] s);
		logic [31:0] p;
		logic [31:0] e;
		logic [31:0] m;
		logic [31:0] c;
		logic [31:0] mask;
		p = 32'd1 + (INC_INV * (LCG_MUL - 32'd1)) * s;
		e = 32'd0;
		for (int k = 3; k < 32; k++) begin
			mask = (32'd1 << k) - 32'd1;
			lcg_power(e, m, c);
			if ((m & mask) != (p & mask))
				e += 32'd1 << (k - 3);
		end
		lcg_power(e, m, c);
		if (m != p)
			e += 32'd1 << 29;
		for (int t = 0; t < 3; t++) begin
			if (lcg_advance(32'd0, e) == s)
				break;
			e += 32'd1 << 30;
		end
		return e;
	endfunction

	function automatic lcg_res_t predict_result(input cmd_t cmd, input logic [31:0] seed,
			input logic [31:0] cnt);
		lcg_res_t r;
		r = '0;
		case (cmd)
			CMD_JUMP:   r.seed_out = lcg_advance(seed, cnt);
			CMD_INDEX:  r.seed_out = lcg_advance(origin_seed, cnt);
			CMD_LOCATE: begin
				r.seed_out = seed;
				r.index_out = lcg_index_of(seed) - lcg_index_of(origin_seed);
			end
			default:    r = '0;
		endcase
		if (cmd != CMD_NONE)
			r.random_value = r.seed_out[30:16];
		return r;
	endfunction

	// cycle counter and watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles,
				expected_q.size());
			$display("[lcg_jump_and_index_recovery_top] ERROR");
			$finish;
		end
	end

	// receiver: random stalls, plus a long hold-off while hold_off is set
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// output checker: compares each transfer with the oldest expectation
	always @(posedge clk) begin
		lcg_res_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			n_got <= n_got + 1;
			if (expected_q.size() == 0) begin
				$error("unexpected result seed_out=%h", out_ch.seed_out);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (out_ch.seed_out !== e.seed_out) begin
					$error("seed_out: expected %h, got %h", e.seed_out, out_ch.seed_out);
					errors++;
				end
				if (out_ch.index_out !== e.index_out) begin
					$error("index_out: expected %h, got %h", e.index_out, out_ch.index_out);
					errors++;
				end
				if (out_ch.random_value !== e.random_value) begin
					$error("random_value: expected %h, got %h", e.random_value,
						out_ch.random_value);
					errors++;
				end
			end
		end
	end

	// offer one item; the expectation is queued on the accepting edge.
	// valid stays high after the transfer so back-to-back items need no gap
	task automatic send_item(input cmd_t cmd, input logic [31:0] seed, input logic [31:0] cnt,
			input logic known, input lcg_res_t res);
		lcg_res_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.cmd <= cmd;
		in_ch.seed_in <= seed;
		in_ch.step_count <= cnt;
		do
			@(posedge clk);
		while (!in_ch.ready);
		r = predict_result(cmd, seed, cnt);
		if (known && r !== res) begin
			$error("predictor disagrees with directed row: expected %h, predicted %h", res, r);
			errors++;
		end
		expected_q.push_back(r);
		n_sent++;
		n_cmd[cmd]++;
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// register write, only with the pipe empty
	task automatic write_start(input logic [31:0] v);
		drain();
		cfg.valid <= 1'b1;
		cfg.data <= v;
		do
			@(posedge clk);
		while (!cfg.ready);
		cfg.valid <= 1'b0;
		origin_seed = v;
		n_cfg++;
	endtask

	// random item: mostly real commands, locate lookups sometimes aimed at seeds jumped from the start seed
	task automatic send_random();
		cmd_t        cmd;
		logic [31:0] seed;
		logic [31:0] cnt;
		int          r;
		r = $urandom_range(99);
		cmd = r < 30 ? CMD_JUMP : r < 60 ? CMD_INDEX : r < 95 ? CMD_LOCATE : CMD_NONE;
		seed = $urandom();
		cnt = $urandom_range(3) == 0 ? 32'($urandom_range(64)) : $urandom();
		if (cmd == CMD_LOCATE && $urandom_range(3) == 0)
			seed = lcg_advance(origin_seed, cnt);
		send_item(cmd, seed, cnt, 1'b0, '0);
	endtask

	// directed rows; results typed in where obvious
	dir_row_t dir_rows[] = '{
		'{CMD_JUMP,   32'h0000_0000, 32'd0,        1'b1, '{32'h0, 32'h0, 15'h0}},
		'{CMD_JUMP,   32'hFFFF_FFFF, 32'd0,        1'b1, '{32'hFFFF_FFFF, 32'h0, 15'h7FFF}},
		'{CMD_JUMP,   32'h0000_0000, 32'd1,        1'b1, '{32'd12345, 32'h0, 15'h0}},
		'{CMD_JUMP,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
		'{CMD_JUMP,   32'h1234_5678, 32'h8000_0000, 1'b0, '0},
		'{CMD_INDEX,  32'h0,         32'd0,        1'b1, '{32'h5555_5555, 32'h0, 15'h5555}},
		'{CMD_INDEX,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
		'{CMD_INDEX,  32'h0,         32'd1,        1'b0, '0},
		'{CMD_LOCATE, 32'h5555_5555, 32'd0,        1'b1, '{32'h5555_5555, 32'h0, 15'h5555}},
		'{CMD_LOCATE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, '0},
		'{CMD_LOCATE, 32'hFFFF_FFFF, 32'd0,        1'b0, '0},
		'{CMD_LOCATE, 32'hDEAD_BEEF, 32'd7,        1'b0, '0},
		'{CMD_LOCATE, 32'h0000_3039, 32'd0,        1'b0, '0},
		'{CMD_NONE,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'h0, 32'h0, 15'h0}},
		'{CMD_NONE,   32'h0,         32'h0,        1'b1, '{32'h0, 32'h0, 15'h0}}
	};

	// long receiver hold-off, timed in its own process
	task automatic press_pipe();
		fork
			begin
				hold_off = 1'b1;
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end
			begin
				for (int i = 0; i < 80; i++)
					send_random();
			end
		join
	endtask

	initial begin
		logic [31:0] settings[4];
		in_ch.valid = 1'b0;
		in_ch.cmd = '0;
		in_ch.seed_in = '0;
		in_ch.step_count = '0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		origin_seed = START_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table against the reset start seed
		foreach (dir_rows[i])
			send_item(dir_rows[i].cmd, dir_rows[i].seed, dir_rows[i].cnt,
				dir_rows[i].known, dir_rows[i].res);

		// after a write of zero, step 1 from start gives the increment
		write_start(32'h0);
		send_item(CMD_INDEX, 32'h0, 32'd1, 1'b1, '{32'd12345, 32'h0, 15'h0});
		send_item(CMD_LOCATE, 32'd12345, 32'd0, 1'b1, '{32'd12345, 32'd1, 15'h0});

		// random phases over several start seeds and idling mixes
		settings = '{32'hFFFF_FFFF, $urandom(), 32'h0, START_RESET};
		for (int ph = 0; ph < 4; ph++) begin
			write_start(settings[ph]);
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
				default: begin send_idle_pct = 18; recv_stall_pct = 18; end
			endcase
			for (int i = 0; i < 280; i++)
				send_random();
			if (ph == 0)
				press_pipe();
		end

		drain();
		$display("%0d items (jump %0d, index %0d, locate %0d, unused %0d), %0d results,",
			n_sent, n_cmd[0], n_cmd[1], n_cmd[2], n_cmd[3], n_got);
		$display("%0d start seed writes, %0d cycles", n_cfg, cycles);
		if (errors == 0)
			$display("[lcg_jump_and_index_recovery_top] OK");
		else
			$display("[lcg_jump_and_index_recovery_top] ERROR");
		$finish;
	end

endmodule

`default_nettype wire

/* lcg_jump_and_index_recovery_top.f */
rtl/lji_pkg.sv
rtl/lji_ifs.sv
rtl/lji_stage.sv
rtl/lji_finish.sv
rtl/lcg_jump_and_index_recovery_top.sv
tb/sv/tb_lcg_jump_and_index_recovery_top.sv
